// File: design/fmad_pkg.sv
// ----------------------------------------------------------------------------
// fmad_pkg - shared types and constants
// Field widths, configuration register indexes, control states and the
// divider status record for the force moving-average deadband block.
// ----------------------------------------------------------------------------
package fmad_pkg;

  localparam int FORCE_W   = 16;  // Q8.8 force and velocity
  localparam int THRESH_W  = 15;
  localparam int GAIN_W    = 16;  // Q0.16
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;

  localparam logic [THRESH_W-1:0] THRESH_RESET = THRESH_W'(512);
  localparam logic [GAIN_W-1:0]   GAIN_RESET   = GAIN_W'(1311);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RUN_ENABLE     = 2'd0,
    CFG_DEAD_THRESHOLD = 2'd1,
    CFG_GAIN           = 2'd2
  } cfg_index_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIV,
    ST_AVG,
    ST_PROD,
    ST_WB
  } ctrl_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

// File: design/fmad_if.sv
// ----------------------------------------------------------------------------
// fmad channel interfaces
// Valid/ready channels for force samples, results and register writes.
// ----------------------------------------------------------------------------
interface fmad_in_if;
  import fmad_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [FORCE_W-1:0] force_x;
  modport source (output valid, output force_x, input ready);
  modport sink   (input valid, input force_x, output ready);
endinterface

interface fmad_out_if;
  import fmad_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [FORCE_W-1:0] velocity_x;
  logic signed [FORCE_W-1:0] average_force_x;
  modport source (output valid, output velocity_x, output average_force_x, input ready);
  modport sink   (input valid, input velocity_x, input average_force_x, output ready);
endinterface

interface fmad_cfg_if;
  import fmad_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: design/fmad_cell.sv
// ----------------------------------------------------------------------------
// fmad_cell - one window cell
// Holds one force sample and takes its neighbour's sample on each shift.
// ----------------------------------------------------------------------------
module fmad_cell (
  input  logic                               clk,
  input  logic                               shift,
  input  logic signed [fmad_pkg::FORCE_W-1:0] d,
  output logic signed [fmad_pkg::FORCE_W-1:0] q
);
  import fmad_pkg::*;

  logic signed [FORCE_W-1:0] sample_r;

  always_ff @(posedge clk) begin
    if (shift) begin
      sample_r <= d;
    end
  end

  assign q = sample_r;

endmodule

// File: design/fmad_div.sv
// ----------------------------------------------------------------------------
// fmad_div - serial unsigned divider
// Restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module fmad_div #(
  parameter int DIVIDEND_W = 21,
  parameter int DIVISOR_W  = 5
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [DIVIDEND_W-1:0]      dividend,
  input  logic [DIVISOR_W-1:0]       divisor,
  output logic [DIVIDEND_W-1:0]      quotient,
  output fmad_pkg::div_status_t      status
);
  import fmad_pkg::*;

  localparam int CNT_W = $clog2(DIVIDEND_W + 1);

  logic [DIVISOR_W:0]    rem_r,  rem_nxt;
  logic [DIVIDEND_W-1:0] quo_r,  quo_nxt;
  logic [DIVISOR_W-1:0]  dsr_r;
  logic [CNT_W-1:0]      cnt_r,  cnt_nxt;
  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [DIVISOR_W:0]    rem_shift;
  logic                  ge;

  // remainder stays below the divisor, so its top bit is free for the shift
  assign rem_shift = {rem_r[DIVISOR_W-1:0], quo_r[DIVIDEND_W-1]};
  assign ge        = rem_shift >= {1'b0, dsr_r};

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start && !busy_r) begin
      rem_nxt  = '0;
      quo_nxt  = dividend;
      cnt_nxt  = CNT_W'(DIVIDEND_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = ge ? (rem_shift - {1'b0, dsr_r}) : rem_shift;
      quo_nxt = {quo_r[DIVIDEND_W-2:0], ge};
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    if (start && !busy_r) begin
      dsr_r <= divisor;
    end
  end

  assign quotient    = quo_r;
  assign status.busy = busy_r;
  assign status.done = done_r;

endmodule

// File: design/force_moving_average_deadband.sv
// ----------------------------------------------------------------------------
// force_moving_average_deadband - windowed force average with deadband
// Averages the last WINDOW force samples and turns the average into a
// velocity command, zero inside the deadband.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch   : one signed Q8.8 force item per handshake (force_x).
//   out_ch  : one result item per enabled input item: velocity_x and
//             average_force_x, both signed Q8.8.
//   cfg_ch  : register writes, always ready. 0 run_enable, 1 dead_threshold,
//             2 gain; other indexes are dropped. Write only while idle.
// With run_enable low, input items are taken and dropped, state untouched.
// An item passes the states LOAD, DIV, AVG, PROD and WB after it is taken,
//   then reaches the output register; the serial divider, one quotient bit
//   a cycle over the SUM_W-bit running sum, is the long step. One item is in
//   work at a time, so the next is taken only back in IDLE.
// The output register holds the last result while the receiver stalls and
//   the next item may already be taken; it is written only once freed.
// Reset (rst_n low, synchronous) empties the window, clears the sum and
//   restores the register defaults. Window cells need no reset: a cell is
//   only read once the fill count says it holds a sample.
// ----------------------------------------------------------------------------
module force_moving_average_deadband #(
  parameter int WINDOW = 20
) (
  input logic       clk,
  input logic       rst_n,
  fmad_in_if.sink   in_ch,
  fmad_out_if.source out_ch,
  fmad_cfg_if.sink  cfg_ch
);
  import fmad_pkg::*;

  localparam int FILL_W = $clog2(WINDOW + 1);
  localparam int SUM_W  = FORCE_W + $clog2(WINDOW);

  // configuration registers
  logic                run_enable_r;
  logic [THRESH_W-1:0] dead_thr_r;
  logic [GAIN_W-1:0]   gain_r;

  // control
  ctrl_state_t state_r, state_nxt;
  logic        in_take;
  logic        shift;
  logic        div_start;
  logic        out_load;
  div_status_t div_stat;

  // window chain: cell 0 holds the newest sample, the last cell the oldest
  logic signed [FORCE_W-1:0] cell_q [WINDOW];

  logic signed [SUM_W-1:0] sum_r, sum_nxt;
  logic [FILL_W-1:0]       fill_r, fill_nxt;
  logic                    full;

  // divider side
  logic                    sum_neg;
  logic [SUM_W-1:0]        sum_mag;
  logic [SUM_W-1:0]        quo;
  logic                    neg_r;

  // average, deadband and product
  logic signed [FORCE_W-1:0] avg_w;
  logic signed [FORCE_W:0]   avg_abs;
  logic signed [FORCE_W-1:0] avg_r;
  logic                      beyond_r;
  logic signed [32:0]        prod_r;
  logic signed [16:0]        prod_hi;
  logic signed [17:0]        vel_neg;
  logic signed [FORCE_W-1:0] vel_w;

  logic                      out_valid_r;
  logic signed [FORCE_W-1:0] out_vel_r;
  logic signed [FORCE_W-1:0] out_avg_r;

  // ---------------------------------------------------------------- config
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_enable_r <= 1'b0;
      dead_thr_r   <= THRESH_RESET;
      gain_r       <= GAIN_RESET;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        CFG_RUN_ENABLE:     run_enable_r <= cfg_ch.data[0];
        CFG_DEAD_THRESHOLD: dead_thr_r   <= cfg_ch.data[THRESH_W-1:0];
        CFG_GAIN:           gain_r       <= cfg_ch.data[GAIN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // ------------------------------------------------------------ sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_ch.valid && run_enable_r) state_nxt = ST_LOAD;
      end
      ST_LOAD: state_nxt = ST_DIV;
      ST_DIV: begin
        if (div_stat.done) state_nxt = ST_AVG;
      end
      ST_AVG:  state_nxt = ST_PROD;
      ST_PROD: state_nxt = ST_WB;
      ST_WB: begin
        if (!out_valid_r || out_ch.ready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ch.ready = 1'b0;
    div_start   = 1'b0;
    out_load    = 1'b0;
    case (state_r)
      ST_IDLE: in_ch.ready = 1'b1;
      ST_LOAD: div_start   = 1'b1;
      ST_WB:   out_load    = !out_valid_r || out_ch.ready;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_take = in_ch.valid && in_ch.ready;
  assign shift   = in_take && run_enable_r;

  // ---------------------------------------------------------- window chain
  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    if (i == 0) begin : g_head
      fmad_cell u_cell (.clk(clk), .shift(shift), .d(in_ch.force_x), .q(cell_q[i]));
    end else begin : g_link
      fmad_cell u_cell (.clk(clk), .shift(shift), .d(cell_q[i-1]), .q(cell_q[i]));
    end
  end

  assign full = fill_r == FILL_W'(WINDOW);

  // once full, the oldest sample drops off the end of the chain
  always_comb begin
    sum_nxt  = sum_r;
    fill_nxt = fill_r;
    if (shift) begin
      sum_nxt = sum_r + SUM_W'(in_ch.force_x)
              - (full ? SUM_W'(cell_q[WINDOW-1]) : SUM_W'(0));
      if (!full) fill_nxt = fill_r + FILL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r  <= '0;
      fill_r <= '0;
    end else begin
      sum_r  <= sum_nxt;
      fill_r <= fill_nxt;
    end
  end

  // --------------------------------------------------------------- divide
  // divide magnitudes, restore the sign afterwards (truncation toward zero)
  assign sum_neg = sum_r[SUM_W-1];
  assign sum_mag = sum_neg ? SUM_W'(-sum_r) : SUM_W'(sum_r);

  always_ff @(posedge clk) begin
    if (div_start) neg_r <= sum_neg;
  end

  fmad_div #(
    .DIVIDEND_W (SUM_W),
    .DIVISOR_W  (FILL_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_mag),
    .divisor  (fill_r),
    .quotient (quo),
    .status   (div_stat)
  );

  // |avg| <= 32768, so the low bits carry it; -32768 wraps onto itself
  assign avg_w   = neg_r ? -$signed(quo[FORCE_W-1:0]) : $signed(quo[FORCE_W-1:0]);
  assign avg_abs = avg_w[FORCE_W-1] ? -{avg_w[FORCE_W-1], avg_w}
                                    : {avg_w[FORCE_W-1], avg_w};

  always_ff @(posedge clk) begin
    if (state_r == ST_AVG) begin
      avg_r    <= avg_w;
      beyond_r <= avg_abs > $signed({2'b00, dead_thr_r});
    end
    if (state_r == ST_PROD) begin
      prod_r <= $signed({1'b0, gain_r}) * avg_r;
    end
  end

  // floor shift by 16, negate, saturate; zero inside the deadband
  assign prod_hi = prod_r[32:16];
  assign vel_neg = -{prod_hi[16], prod_hi};

  always_comb begin
    if (!beyond_r) begin
      vel_w = '0;
    end else if (vel_neg > 18'sd32767) begin
      vel_w = 16'sh7FFF;
    end else if (vel_neg < -18'sd32768) begin
      vel_w = 16'sh8000;
    end else begin
      vel_w = vel_neg[FORCE_W-1:0];
    end
  end

  // -------------------------------------------------------- output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_vel_r <= vel_w;
      out_avg_r <= avg_r;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.velocity_x      = out_vel_r;
  assign out_ch.average_force_x = out_avg_r;

  // ------------------------------------------------------------ assertions
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_W'(WINDOW))
    else $error("fill count beyond window");

  a_fill_moves_on_take: assert property (@(posedge clk) disable iff (!rst_n)
    (fill_r != $past(fill_r)) |-> $past(in_take && run_enable_r))
    else $error("fill count moved without an enabled item");

  a_result_from_wb: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_WB))
    else $error("result raised outside write-back");

  a_div_only_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.done |-> (state_r == ST_DIV))
    else $error("divider finished outside divide state");

endmodule
